/* src/lpp_pkg.sv */
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants of the length-prefixed packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpp_pkg;

	// Default number of little-endian length bytes in a packet header.
	localparam int LENGTH_BYTES_DEF = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_START    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_CONTINUE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_STOP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_CLEAR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_SLEEP    = 3'd4;

	// Reset values of the configured ids.
	localparam logic [7:0] RST_ID_START    = 8'd0;
	localparam logic [7:0] RST_ID_CONTINUE = 8'd1;
	localparam logic [7:0] RST_ID_STOP     = 8'd2;
	localparam logic [7:0] RST_ID_CLEAR    = 8'd3;
	localparam logic [7:0] RST_ID_SLEEP    = 8'd4;

	// Event kinds of a result item.
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CONTINUE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STOP     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SLEEP    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd6;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [7:0]        out_byte;
		logic              draw_enabled;
		logic              packet_end;
	} result_t;

	// Handshake between the input register and the parser core.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} item_t;

endpackage

`default_nettype wire

/* src/lpp_in_reg.sv */
// ----------------------------------------------------------------------------
// lpp_in_reg
// Input register: holds one accepted byte until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_stall,
	input  wire logic [7:0]     in_byte,
	input  wire logic           advance,
	output      lpp_pkg::item_t item_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       load;

	// The register takes a new item when it is empty or its item moves on.
	assign load     = !valid_s1 || advance;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign item_s1.valid = valid_s1;
	assign item_s1.data  = byte_s1;

endmodule

`default_nettype wire

/* src/lpp_core.sv */
// ----------------------------------------------------------------------------
// lpp_core
// Parser state, configured ids and the result of the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_core #(
	parameter int LENGTH_BYTES = lpp_pkg::LENGTH_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire lpp_pkg::item_t                 item_s1,
	input  wire logic                           advance,
	output      logic                           emits,
	output      lpp_pkg::result_t               result
);

	localparam int LEN_W = 8 * LENGTH_BYTES;
	localparam int HDR_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
	localparam logic [HDR_W-1:0] HDR_LAST = HDR_W'(LENGTH_BYTES - 1);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_ID     = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	phase_t            phase_q;
	logic [HDR_W-1:0]  hdr_cnt_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic              draw_q;
	logic [7:0]        id_start_q, id_continue_q, id_stop_q, id_clear_q, id_sleep_q;

	logic [LEN_W+7:0]  len_shift;
	logic [LEN_W:0]    cnt_next;
	logic              pkt_end;
	logic [lpp_pkg::KIND_W-1:0] id_kind;
	logic              draw_id;

	// Header bytes arrive least significant first, so shifting each one in
	// from the top leaves the first byte at the bottom after the last one.
	assign len_shift = {item_s1.data, len_q};
	assign cnt_next  = {1'b0, cnt_q} + {{LEN_W{1'b0}}, 1'b1};
	assign pkt_end   = cnt_next >= {1'b0, len_q};

	// The first matching register wins.
	always_comb begin
		if (item_s1.data == id_start_q) begin
			id_kind = lpp_pkg::KIND_START;
		end else if (item_s1.data == id_continue_q) begin
			id_kind = lpp_pkg::KIND_CONTINUE;
		end else if (item_s1.data == id_stop_q) begin
			id_kind = lpp_pkg::KIND_STOP;
		end else if (item_s1.data == id_clear_q) begin
			id_kind = lpp_pkg::KIND_CLEAR;
		end else if (item_s1.data == id_sleep_q) begin
			id_kind = lpp_pkg::KIND_SLEEP;
		end else begin
			id_kind = lpp_pkg::KIND_UNKNOWN;
		end
	end

	always_comb begin
		case (id_kind) inside
			lpp_pkg::KIND_START: begin
				draw_id = draw_q;
			end
			lpp_pkg::KIND_CONTINUE, lpp_pkg::KIND_STOP: begin
				draw_id = 1'b1;
			end
			default: begin
				draw_id = 1'b0;
			end
		endcase
	end

	always_comb begin
		emits  = 1'b0;
		result = '0;
		unique case (phase_q)
			PH_ID: begin
				emits               = 1'b1;
				result.event_kind   = id_kind;
				result.out_byte     = item_s1.data;
				result.draw_enabled = draw_id;
				result.packet_end   = 1'b0;
			end
			PH_DATA: begin
				emits               = 1'b1;
				result.event_kind   = lpp_pkg::KIND_DATA;
				result.out_byte     = item_s1.data;
				result.draw_enabled = draw_q && !pkt_end;
				result.packet_end   = pkt_end;
			end
			default: begin
				emits = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			cnt_q     <= '0;
			len_q     <= '0;
			draw_q    <= 1'b0;
		end else if (advance) begin
			unique case (phase_q)
				PH_HEADER: begin
					len_q <= len_shift[LEN_W+7:8];
					if (hdr_cnt_q == HDR_LAST) begin
						hdr_cnt_q <= '0;
						phase_q   <= PH_ID;
					end else begin
						hdr_cnt_q <= hdr_cnt_q + HDR_W'(1);
					end
				end
				PH_ID: begin
					draw_q  <= draw_id;
					cnt_q   <= LEN_W'(1);
					phase_q <= PH_DATA;
				end
				PH_DATA: begin
					if (pkt_end) begin
						phase_q <= PH_HEADER;
						cnt_q   <= '0;
						len_q   <= '0;
						draw_q  <= 1'b0;
					end else begin
						cnt_q <= cnt_next[LEN_W-1:0];
					end
				end
				default: begin
					phase_q   <= PH_HEADER;
					hdr_cnt_q <= '0;
					cnt_q     <= '0;
					len_q     <= '0;
					draw_q    <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_start_q    <= lpp_pkg::RST_ID_START;
			id_continue_q <= lpp_pkg::RST_ID_CONTINUE;
			id_stop_q     <= lpp_pkg::RST_ID_STOP;
			id_clear_q    <= lpp_pkg::RST_ID_CLEAR;
			id_sleep_q    <= lpp_pkg::RST_ID_SLEEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpp_pkg::CFG_ID_START:    id_start_q    <= cfg_data;
				lpp_pkg::CFG_ID_CONTINUE: id_continue_q <= cfg_data;
				lpp_pkg::CFG_ID_STOP:     id_stop_q     <= cfg_data;
				lpp_pkg::CFG_ID_CLEAR:    id_clear_q    <= cfg_data;
				lpp_pkg::CFG_ID_SLEEP:    id_sleep_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/lpp_out_reg.sv */
// ----------------------------------------------------------------------------
// lpp_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire lpp_pkg::result_t result,
	output      logic             free,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      lpp_pkg::result_t result_q
);

	logic valid_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

/* src/length_prefixed_packet_parser_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_parser_top
// Parses a byte stream of length-prefixed packets into command and data items.
//
// Input channel (in_valid, in_stall, in_byte) takes one byte per item. Each
// packet is LENGTH_BYTES little-endian length bytes, one id byte and then the
// data bytes. Header bytes give no result; the id byte gives a command item
// and each data byte a data item on (out_valid, out_stall, event_kind,
// out_byte, draw_enabled, packet_end). The last data byte of a packet has
// packet_end set.
// An accepted byte is held in the input register; a byte that gives a result
// moves on into the result register when that has room, and its item then
// shows on out_valid. One byte is accepted per cycle unless a stalled result
// holds it back; the input register and the result register let a new byte
// in while a finished item still waits. When the receiver stalls, the item
// holds and in_stall rises once the input register holds a byte that gives
// a result. The id registers are written through (cfg_valid, cfg_ready,
// cfg_index, cfg_data), always ready; indexes beyond the last are ignored.
// Reset clears the parser to the start of a header and loads the default ids.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_parser_top #(
	parameter int LENGTH_BYTES = lpp_pkg::LENGTH_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [7:0]                    in_byte,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [lpp_pkg::KIND_W-1:0]    event_kind,
	output      logic [7:0]                    out_byte,
	output      logic                          draw_enabled,
	output      logic                          packet_end,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [lpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);

	lpp_pkg::item_t   item_s1;
	lpp_pkg::result_t result;
	lpp_pkg::result_t result_q;
	logic             emits;
	logic             free;
	logic             advance;

	assign cfg_ready = 1'b1;

	// A header byte needs no room in the result register.
	assign advance = item_s1.valid && (!emits || free);

	lpp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	lpp_core #(
		.LENGTH_BYTES (LENGTH_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_s1   (item_s1),
		.advance   (advance),
		.emits     (emits),
		.result    (result)
	);

	lpp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emits),
		.result    (result),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_q  (result_q)
	);

	assign event_kind   = result_q.event_kind;
	assign out_byte     = result_q.out_byte;
	assign draw_enabled = result_q.draw_enabled;
	assign packet_end   = result_q.packet_end;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for length_prefixed_packet_parser_top. A short table of
// packets after reset covers every id kind and the short lengths. Random
// packets then follow under several id settings, including all-equal and
// extreme values. Results are checked in order against the table or a local
// parser model, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------

module testbench;

	localparam int NUM_IDS     = 5;
	localparam int HDR_BYTES   = lpp_pkg::LENGTH_BYTES_DEF;
	localparam int PIPE_LAT    = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 36;
	localparam int DIR_ROWS    = 37;

	typedef enum logic [1:0] {PH_HEADER, PH_ID, PH_DATA} parse_phase_t;

	typedef struct packed {
		logic             fixed;
		logic [7:0]       value;
		lpp_pkg::result_t want;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    in_byte;
	logic                          out_valid;
	logic                          out_stall;
	logic [lpp_pkg::KIND_W-1:0]    event_kind;
	logic [7:0]                    out_byte;
	logic                          draw_enabled;
	logic                          packet_end;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [lpp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	// Typed expectation that travels with the byte being offered.
	logic             row_fixed;
	lpp_pkg::result_t row_want;

	// Parser model state and its copy of the id registers.
	parse_phase_t ph;
	logic [31:0]  byte_cnt;
	logic [31:0]  pkt_len;
	logic         draw;
	logic [7:0]   id_reg [NUM_IDS];
	logic [7:0]   next_ids [NUM_IDS];

	lpp_pkg::result_t pending_results [$];
	dir_row_t         dir_rows [DIR_ROWS];

	int  errors;
	int  bytes_taken;
	int  results_checked;
	int  packets_sent;
	int  quiet_cycles;
	bit  run_done;
	bit  tx_idle_on;
	bit  rx_idle_on;

	length_prefixed_packet_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.out_byte     (out_byte),
		.draw_enabled (draw_enabled),
		.packet_end   (packet_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic note_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Advances the parser model by one byte; got is set when a result is due.
	function automatic void parse_byte(input logic [7:0] b, output bit got,
			output lpp_pkg::result_t res);
		int hit;
		int k;
		logic [lpp_pkg::KIND_W-1:0] kind;
		got = 1'b0;
		res = '0;
		case (ph)
			PH_HEADER: begin
				pkt_len = pkt_len | (32'(b) << (8 * byte_cnt[1:0]));
				byte_cnt = byte_cnt + 1;
				if (byte_cnt >= HDR_BYTES) begin
					byte_cnt = '0;
					ph = PH_ID;
				end
			end
			PH_ID: begin
				// Scanning downward leaves the lowest matching register, so start wins ties.
				hit = -1;
				for (k = NUM_IDS - 1; k >= 0; k--)
					if (b == id_reg[k])
						hit = k;
				case (hit)
					0: kind = lpp_pkg::KIND_START;
					1: kind = lpp_pkg::KIND_CONTINUE;
					2: kind = lpp_pkg::KIND_STOP;
					3: kind = lpp_pkg::KIND_CLEAR;
					4: kind = lpp_pkg::KIND_SLEEP;
					default: kind = lpp_pkg::KIND_UNKNOWN;
				endcase
				if (kind == lpp_pkg::KIND_CONTINUE || kind == lpp_pkg::KIND_STOP)
					draw = 1'b1;
				else if (kind != lpp_pkg::KIND_START)
					draw = 1'b0;
				ph = PH_DATA;
				byte_cnt = 32'd1;
				res = '{kind, b, draw, 1'b0};
				got = 1'b1;
			end
			PH_DATA: begin
				byte_cnt = byte_cnt + 1;
				res.packet_end = 1'b0;
				if (byte_cnt >= pkt_len) begin
					ph = PH_HEADER;
					byte_cnt = '0;
					pkt_len = '0;
					draw = 1'b0;
					res.packet_end = 1'b1;
				end
				res.event_kind = lpp_pkg::KIND_DATA;
				res.out_byte = b;
				res.draw_enabled = draw;
				got = 1'b1;
			end
			default: begin
				ph = PH_HEADER;
				byte_cnt = '0;
				pkt_len = '0;
				draw = 1'b0;
			end
		endcase
	endfunction

	function automatic dir_row_t silent_row(input logic [7:0] value);
		dir_row_t r;
		r.fixed = 1'b0;
		r.value = value;
		r.want = '0;
		return r;
	endfunction

	function automatic dir_row_t result_row(input logic [7:0] value,
			input logic [lpp_pkg::KIND_W-1:0] kind, input logic drawn, input logic last);
		dir_row_t r;
		r.fixed = 1'b1;
		r.value = value;
		r.want = '{kind, value, drawn, last};
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic fixed,
			input lpp_pkg::result_t want);
		in_valid  <= 1'b1;
		in_byte   <= value;
		row_fixed <= fixed;
		row_want  <= want;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (tx_idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Sends a header for len, the id byte and n_data random data bytes.
	task automatic send_packet(input logic [31:0] len, input logic [7:0] id,
			input int n_data, input bit pause_mid);
		int i;
		for (i = 0; i < HDR_BYTES; i++)
			send_byte(len[8 * i +: 8], 1'b0, '0);
		send_byte(id, 1'b0, '0);
		if (pause_mid)
			drain_results();
		for (i = 0; i < n_data; i++)
			send_byte(8'($urandom), 1'b0, '0);
		packets_sent++;
	endtask

	// Writes next_ids into the id registers, then one write past the last index.
	task automatic program_ids();
		int k;
		cfg_valid <= 1'b1;
		for (k = 0; k <= NUM_IDS; k++) begin
			if (k < NUM_IDS) begin
				cfg_index <= lpp_pkg::CFG_IDX_W'(k);
				cfg_data  <= next_ids[k];
			end else begin
				cfg_index <= lpp_pkg::CFG_ID_SLEEP +
					lpp_pkg::CFG_IDX_W'($urandom_range(1, 3));
				cfg_data  <= 8'($urandom);
			end
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : monitor
		bit               got;
		lpp_pkg::result_t pred;
		lpp_pkg::result_t seen;
		lpp_pkg::result_t want;
		if (in_valid && !in_stall) begin
			bytes_taken++;
			parse_byte(in_byte, got, pred);
			if (got)
				pending_results.push_back(row_fixed ? row_want : pred);
		end
		if (out_valid && !out_stall) begin
			seen = '{event_kind, out_byte, draw_enabled, packet_end};
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected result kind %0d byte %02h",
					seen.event_kind, seen.out_byte));
			end else begin
				want = pending_results.pop_front();
				if (seen.event_kind !== want.event_kind)
					note_error($sformatf("result %0d: event_kind %0d, expected %0d",
						results_checked, seen.event_kind, want.event_kind));
				if (seen.out_byte !== want.out_byte)
					note_error($sformatf("result %0d: out_byte %02h, expected %02h",
						results_checked, seen.out_byte, want.out_byte));
				if (seen.draw_enabled !== want.draw_enabled)
					note_error($sformatf("result %0d: draw_enabled %0b, expected %0b",
						results_checked, seen.draw_enabled, want.draw_enabled));
				if (seen.packet_end !== want.packet_end)
					note_error($sformatf("result %0d: packet_end %0b, expected %0b",
						results_checked, seen.packet_end, want.packet_end));
			end
			results_checked++;
		end
		if (cfg_valid && cfg_ready && cfg_index <= lpp_pkg::CFG_ID_SLEEP)
			id_reg[cfg_index] = cfg_data;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Output stall generator: free runs broken, while rx_idle_on is set, by stalls of random length.
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (rx_idle_on) begin
				out_stall <= 1'b1;
				repeat (idle_len()) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (!run_done && quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		if (!run_done) begin
			$display("length_prefixed_packet_parser_top verification failed");
			$finish;
		end
	end

	initial begin
		int p;
		int k;
		int n;
		int pkt;
		int n_data;
		logic [31:0] len;
		logic [7:0]  id;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		row_fixed = 1'b0;
		row_want = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		bytes_taken = 0;
		results_checked = 0;
		packets_sent = 0;
		quiet_cycles = 0;
		run_done = 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		ph = PH_HEADER;
		byte_cnt = '0;
		pkt_len = '0;
		draw = 1'b0;
		id_reg[lpp_pkg::CFG_ID_START]    = lpp_pkg::RST_ID_START;
		id_reg[lpp_pkg::CFG_ID_CONTINUE] = lpp_pkg::RST_ID_CONTINUE;
		id_reg[lpp_pkg::CFG_ID_STOP]     = lpp_pkg::RST_ID_STOP;
		id_reg[lpp_pkg::CFG_ID_CLEAR]    = lpp_pkg::RST_ID_CLEAR;
		id_reg[lpp_pkg::CFG_ID_SLEEP]    = lpp_pkg::RST_ID_SLEEP;

		// One packet per id kind under the reset ids. Lengths 0, 1 and 2 all
		// end after one data byte; the continue packet shows the flag held.
		dir_rows = '{
			silent_row(8'h03), silent_row(8'h00), silent_row(8'h00), silent_row(8'h00),
			result_row(lpp_pkg::RST_ID_CONTINUE, lpp_pkg::KIND_CONTINUE, 1'b1, 1'b0),
			result_row(8'h00, lpp_pkg::KIND_DATA, 1'b1, 1'b0),
			result_row(8'hff, lpp_pkg::KIND_DATA, 1'b0, 1'b1),
			silent_row(8'h00), silent_row(8'h00), silent_row(8'h00), silent_row(8'h00),
			result_row(lpp_pkg::RST_ID_START, lpp_pkg::KIND_START, 1'b0, 1'b0),
			result_row(8'hff, lpp_pkg::KIND_DATA, 1'b0, 1'b1),
			silent_row(8'h01), silent_row(8'h00), silent_row(8'h00), silent_row(8'h00),
			result_row(lpp_pkg::RST_ID_STOP, lpp_pkg::KIND_STOP, 1'b1, 1'b0),
			result_row(8'h80, lpp_pkg::KIND_DATA, 1'b0, 1'b1),
			silent_row(8'h02), silent_row(8'h00), silent_row(8'h00), silent_row(8'h00),
			result_row(lpp_pkg::RST_ID_CLEAR, lpp_pkg::KIND_CLEAR, 1'b0, 1'b0),
			result_row(8'h7f, lpp_pkg::KIND_DATA, 1'b0, 1'b1),
			silent_row(8'h02), silent_row(8'h00), silent_row(8'h00), silent_row(8'h00),
			result_row(lpp_pkg::RST_ID_SLEEP, lpp_pkg::KIND_SLEEP, 1'b0, 1'b0),
			result_row(8'h55, lpp_pkg::KIND_DATA, 1'b0, 1'b1),
			silent_row(8'h02), silent_row(8'h00), silent_row(8'h00), silent_row(8'h00),
			result_row(8'hff, lpp_pkg::KIND_UNKNOWN, 1'b0, 1'b0),
			result_row(8'haa, lpp_pkg::KIND_DATA, 1'b0, 1'b1)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++)
			send_byte(dir_rows[k].value, dir_rows[k].fixed, dir_rows[k].want);

		for (p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			repeat (PIPE_LAT) @(posedge clk);
			for (k = 0; k < NUM_IDS; k++) begin
				case (p)
					0: next_ids[k] = 8'h00;
					1: next_ids[k] = 8'hff;
					2: next_ids[k] = (k % 2 == 0) ? 8'(k) : 8'(8'hff - k);
					default: next_ids[k] = (k > 0 && $urandom_range(0, 3) == 0) ?
						next_ids[k - 1] : 8'($urandom);
				endcase
			end
			program_ids();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			n = 0;
			pkt = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) :
					$urandom_range(0, 10);
				n_data = (len <= 2) ? 1 : int'(len) - 1;
				id = ($urandom_range(0, 3) != 0) ? next_ids[$urandom_range(0, NUM_IDS - 1)] :
					8'($urandom);
				// In one phase the sender holds off mid-packet until all results are in.
				send_packet(len, id, n_data, p == 2 && pkt == 0);
				n += HDR_BYTES + 1 + n_data;
				pkt++;
			end
		end

		// A huge length with the top bit of every header byte set. The packet
		// cannot finish within the run; only its first data bytes are sent.
		len = $urandom | 32'h8080_8080;
		send_packet(len, next_ids[$urandom_range(0, NUM_IDS - 1)], 30, 1'b0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d results never arrived", pending_results.size()));
		run_done = 1'b1;
		$display("Run covered %0d bytes: the directed packets and %0d random packets",
			bytes_taken, packets_sent);
		$display("under %0d id settings, with %0d results compared.",
			NUM_PHASES + 1, results_checked);
		if (errors == 0)
			$display("length_prefixed_packet_parser_top verification clean");
		else
			$display("length_prefixed_packet_parser_top verification failed");
		$finish;
	end

endmodule

/* filelist.f */
src/lpp_pkg.sv
src/lpp_in_reg.sv
src/lpp_core.sv
src/lpp_out_reg.sv
src/length_prefixed_packet_parser_top.sv
tb/sv/testbench.sv
